// File: design/h264_rtp_fua_packetizer_assert.svh
// ----------------------------------------------------------------------------
// H.264 RTP FU-A packetizer assertion macros
// Shared property forms used by the packetizer's checks.
// ----------------------------------------------------------------------------
`ifndef H264_RTP_FUA_PACKETIZER_ASSERT_SVH
`define H264_RTP_FUA_PACKETIZER_ASSERT_SVH

// ante implies cons in the same cycle
`define HFP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hfp implication check failed");

// cond never holds
`define HFP_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("hfp forbidden condition seen");

`endif

// File: design/hfp_pkg.sv
// ----------------------------------------------------------------------------
// hfp_pkg
// Types and constants shared by the H.264 RTP FU-A packetizer.
// ----------------------------------------------------------------------------
package hfp_pkg;

  localparam int PACKET_BUFFER_BYTES = 1460;
  localparam int LIM_W               = 11;
  localparam logic [LIM_W-1:0] FRAG_MAX = LIM_W'(PACKET_BUFFER_BYTES - 18);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // output byte positions within one command
  localparam int IDX_W = 5;
  localparam logic [IDX_W-1:0] IDX_HDR_LAST = IDX_W'(15);
  localparam logic [IDX_W-1:0] IDX_FU_IND   = IDX_W'(16);
  localparam logic [IDX_W-1:0] IDX_FU_HDR   = IDX_W'(17);
  localparam logic [IDX_W-1:0] IDX_PAYLOAD  = IDX_W'(18);

  localparam logic [7:0] BYTE_DOLLAR  = 8'h24;
  localparam logic [7:0] RTP_V2       = 8'h80;
  localparam logic [7:0] NRI_MASK     = 8'h60;
  localparam logic [7:0] TYPE_MASK    = 8'h1f;
  localparam logic [7:0] FU_A_TYPE    = 8'd28;
  localparam logic [7:0] FU_START_BIT = 8'h80;
  localparam logic [7:0] FU_END_BIT   = 8'h40;
  localparam logic [15:0] LEN_SINGLE  = 16'd12;
  localparam logic [15:0] LEN_FRAG    = 16'd14;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PAYLOAD_TYPE     = 3'd0,
    REG_SOURCE_ID        = 3'd1,
    REG_CHANNEL_NUMBER   = 3'd2,
    REG_FRAGMENT_SIZE    = 3'd3,
    REG_CLOCK_MULTIPLIER = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [6:0]       payload_type;
    logic [31:0]      source_id;
    logic [7:0]       channel_number;
    logic [LIM_W-1:0] fragment_size;
    logic [9:0]       clock_multiplier;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    payload_type:     7'd96,
    source_id:        32'd10,
    channel_number:   8'd0,
    fragment_size:    11'd1350,
    clock_multiplier: 10'd90
  };

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_SINGLE  = 2'd1,
    KIND_FRAG    = 2'd2
  } kind_t;

  // one queued work unit: a payload byte, maybe preceded by a header burst
  typedef struct packed {
    kind_t       kind;
    logic [15:0] rtp_len;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [7:0]  pay;
    logic        pkt_end;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

endpackage

// File: design/hfp_if.sv
// ----------------------------------------------------------------------------
// hfp interfaces
// Valid/ready channels for NAL input, stream output and register writes.
// ----------------------------------------------------------------------------
interface hfp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  nal_byte;
  logic [23:0] nal_size;
  logic [31:0] presentation_time;
  modport source (output valid, nal_byte, nal_size, presentation_time, input ready);
  modport sink   (input valid, nal_byte, nal_size, presentation_time, output ready);
endinterface

interface hfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;
  logic       run_last;
  modport source (output valid, out_byte, packet_end, run_last, input ready);
  modport sink   (input valid, out_byte, packet_end, run_last, output ready);
endinterface

interface hfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/h264_rtp_fua_packetizer.sv
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer
// H.264 NAL bytes in, interleaved RTP (single or FU-A) byte stream out.
// ----------------------------------------------------------------------------
//
//   channel  dir  beat payload
//   in_s     in   nal_byte, nal_size, presentation_time (sizes/time on 1st byte)
//   out_m    out  out_byte, packet_end, run_last
//   cfg_s    in   index (3b), data (32b); always ready
//
// Output: the sequencer sends one byte per cycle while out_m.ready allows; a
// NAL byte yields 1 byte, 17 when it opens a single packet and 19 when it
// opens a fragment. In fragmented mode a NAL's header byte yields no output.
// Input keeps flowing while the 2-entry command queue has room.
// Reset: synchronous, active low; control and config registers return to defaults.
// Stalls: out_m.ready low holds the output register; the queue then fills
// and in_s.ready drops.
// ----------------------------------------------------------------------------
module h264_rtp_fua_packetizer (
  input  logic       clk,
  input  logic       rst_n,
  hfp_in_if.sink     in_s,
  hfp_out_if.source  out_m,
  hfp_cfg_if.sink    cfg_s
);
  import hfp_pkg::*;

  `include "h264_rtp_fua_packetizer_assert.svh"

  cfg_t     cfg_r;
  logic     push;
  logic     pop;
  cmd_t     push_cmd;
  cmd_t     head_cmd;
  fifo_st_t fifo_st;

  // register file; always ready. Header fields read these live, so writes
  // belong between NALs with the pipe drained.
  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_s.valid) begin
      case (cfg_s.index)
        REG_PAYLOAD_TYPE:     cfg_r.payload_type     <= cfg_s.data[6:0];
        REG_SOURCE_ID:        cfg_r.source_id        <= cfg_s.data;
        REG_CHANNEL_NUMBER:   cfg_r.channel_number   <= cfg_s.data[7:0];
        REG_FRAGMENT_SIZE:    cfg_r.fragment_size    <= cfg_s.data[LIM_W-1:0];
        REG_CLOCK_MULTIPLIER: cfg_r.clock_multiplier <= cfg_s.data[9:0];
        default: ;
      endcase
    end
  end

  // front: classify each NAL byte, compute timestamp, sequence number, FU bytes
  hfp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_s     (in_s),
    .fifo_st  (fifo_st),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouples input acceptance from header bursts on the output
  hfp_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .st       (fifo_st)
  );

  // back: one output byte per cycle unless out_m stalls; registered output
  hfp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .head_cmd (head_cmd),
    .fifo_st  (fifo_st),
    .pop      (pop),
    .out_m    (out_m)
  );

  // a packet always closes on the last byte of its input beat
  `HFP_ASSERT_IMPL(a_end_is_last, clk, rst_n, out_m.valid && out_m.packet_end, out_m.run_last)
  // the front never writes into a full queue
  `HFP_ASSERT_IMPL(a_push_room, clk, rst_n, push, !fifo_st.full)
  // the sequencer never pulls from an empty queue
  `HFP_ASSERT_NEVER(a_no_pop_empty, clk, rst_n, pop && fifo_st.empty)

endmodule

// File: design/hfp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// hfp_cmd_fifo
// Short command queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module hfp_cmd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hfp_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output hfp_pkg::cmd_t    head_cmd,
  output hfp_pkg::fifo_st_t st
);
  import hfp_pkg::*;

  cmd_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_cmd = mem_r[rd_ptr_r];
  assign st.full  = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign st.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: design/hfp_front.sv
// ----------------------------------------------------------------------------
// hfp_front
// Accepts NAL bytes, tracks NAL/fragment position, builds queue commands.
// ----------------------------------------------------------------------------
module hfp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  hfp_pkg::cfg_t     cfg,
  hfp_in_if.sink            in_s,
  input  hfp_pkg::fifo_st_t fifo_st,
  output logic              push,
  output hfp_pkg::cmd_t     push_cmd
);
  import hfp_pkg::*;

  logic [15:0]      seq_r, seq_nxt;
  logic [23:0]      nal_left_r, nal_left_nxt;
  logic [LIM_W-1:0] pkt_left_r, pkt_left_nxt;
  logic             frag_r, frag_nxt;
  logic             first_r, first_nxt;
  logic [7:0]       saved_hdr_r, saved_hdr_nxt;
  logic [31:0]      ts_r, ts_nxt;

  logic             accept;
  logic [LIM_W-1:0] lim;
  logic [23:0]      size_fix;
  logic [41:0]      product;
  logic [LIM_W-1:0] chunk;
  logic             last;

  assign in_s.ready = !fifo_st.full;
  assign accept     = in_s.valid && in_s.ready;

  always_comb begin
    if (cfg.fragment_size == '0) begin
      lim = LIM_W'(1);
    end else if (cfg.fragment_size > FRAG_MAX) begin
      lim = FRAG_MAX;
    end else begin
      lim = cfg.fragment_size;
    end
  end

  assign size_fix = (in_s.nal_size == '0) ? 24'd1 : in_s.nal_size;
  assign product  = 42'(in_s.presentation_time) * 42'(cfg.clock_multiplier);
  assign chunk    = (nal_left_r < 24'(lim)) ? nal_left_r[LIM_W-1:0] : lim;
  assign last     = (24'(chunk) == nal_left_r);

  always_comb begin
    seq_nxt       = seq_r;
    nal_left_nxt  = nal_left_r;
    pkt_left_nxt  = pkt_left_r;
    frag_nxt      = frag_r;
    first_nxt     = first_r;
    saved_hdr_nxt = saved_hdr_r;
    ts_nxt        = ts_r;
    push          = 1'b0;

    push_cmd.kind    = KIND_PAYLOAD;
    push_cmd.rtp_len = '0;
    push_cmd.marker  = 1'b0;
    push_cmd.seq     = seq_r;
    push_cmd.ts      = ts_r;
    push_cmd.fu_ind  = (saved_hdr_r & NRI_MASK) | FU_A_TYPE;
    push_cmd.fu_hdr  = (saved_hdr_r & TYPE_MASK) | (first_r ? FU_START_BIT : 8'h00)
                       | (last ? FU_END_BIT : 8'h00);
    push_cmd.pay     = in_s.nal_byte;
    push_cmd.pkt_end = (pkt_left_r == LIM_W'(1));

    if (accept) begin
      if (nal_left_r == '0) begin
        ts_nxt = product[31:0];
        if (size_fix < 24'(lim)) begin
          // whole NAL in one packet
          frag_nxt         = 1'b0;
          first_nxt        = 1'b0;
          nal_left_nxt     = size_fix - 24'd1;
          pkt_left_nxt     = size_fix[LIM_W-1:0] - LIM_W'(1);
          push             = 1'b1;
          push_cmd.kind    = KIND_SINGLE;
          push_cmd.rtp_len = 16'(size_fix[LIM_W-1:0]) + LEN_SINGLE;
          push_cmd.marker  = 1'b1;
          push_cmd.ts      = product[31:0];
          push_cmd.pkt_end = (size_fix == 24'd1);
          seq_nxt          = seq_r + 16'd1;
        end else begin
          // header byte folds into FU bytes; nothing goes out now
          frag_nxt      = 1'b1;
          first_nxt     = 1'b1;
          saved_hdr_nxt = in_s.nal_byte;
          nal_left_nxt  = size_fix - 24'd1;
          pkt_left_nxt  = '0;
        end
      end else if (frag_r && pkt_left_r == '0) begin
        push             = 1'b1;
        push_cmd.kind    = KIND_FRAG;
        push_cmd.rtp_len = 16'(chunk) + LEN_FRAG;
        push_cmd.marker  = last;
        push_cmd.pkt_end = (chunk == LIM_W'(1));
        first_nxt        = 1'b0;
        pkt_left_nxt     = chunk - LIM_W'(1);
        nal_left_nxt     = nal_left_r - 24'd1;
        seq_nxt          = seq_r + 16'd1;
      end else begin
        push         = 1'b1;
        pkt_left_nxt = pkt_left_r - LIM_W'(1);
        nal_left_nxt = nal_left_r - 24'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= '0;
      nal_left_r  <= '0;
      pkt_left_r  <= '0;
      frag_r      <= 1'b0;
      first_r     <= 1'b0;
      saved_hdr_r <= '0;
      ts_r        <= '0;
    end else begin
      seq_r       <= seq_nxt;
      nal_left_r  <= nal_left_nxt;
      pkt_left_r  <= pkt_left_nxt;
      frag_r      <= frag_nxt;
      first_r     <= first_nxt;
      saved_hdr_r <= saved_hdr_nxt;
      ts_r        <= ts_nxt;
    end
  end

endmodule

// File: design/hfp_back.sv
// ----------------------------------------------------------------------------
// hfp_back
// Byte sequencer: expands queued commands into the framed output stream.
// ----------------------------------------------------------------------------
module hfp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  hfp_pkg::cfg_t     cfg,
  input  hfp_pkg::cmd_t     head_cmd,
  input  hfp_pkg::fifo_st_t fifo_st,
  output logic              pop,
  hfp_out_if.source         out_m
);
  import hfp_pkg::*;

  logic             active_r, active_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       obyte_r, obyte_nxt;
  logic             oend_r, oend_nxt;
  logic             olast_r, olast_nxt;

  logic             step;
  logic             at_pay;
  logic [127:0]     hdr;
  logic [7:0]       cur_byte;

  assign step   = active_r && (!ovalid_r || out_m.ready);
  assign at_pay = (idx_r == IDX_PAYLOAD);
  assign pop    = !fifo_st.empty && (!active_r || (step && at_pay));

  assign hdr = {BYTE_DOLLAR, cfg.channel_number, cmd_r.rtp_len, RTP_V2,
                cmd_r.marker, cfg.payload_type, cmd_r.seq, cmd_r.ts, cfg.source_id};

  always_comb begin
    if (idx_r <= IDX_HDR_LAST) begin
      cur_byte = hdr[8'd127 - {idx_r[3:0], 3'b000} -: 8];
    end else if (idx_r == IDX_FU_IND) begin
      cur_byte = cmd_r.fu_ind;
    end else if (idx_r == IDX_FU_HDR) begin
      cur_byte = cmd_r.fu_hdr;
    end else begin
      cur_byte = cmd_r.pay;
    end
  end

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    cmd_nxt    = cmd_r;
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    oend_nxt   = oend_r;
    olast_nxt  = olast_r;

    if (step) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = cur_byte;
      oend_nxt   = at_pay && cmd_r.pkt_end;
      olast_nxt  = at_pay;
    end else if (out_m.ready) begin
      ovalid_nxt = 1'b0;
    end

    if (pop) begin
      active_nxt = 1'b1;
      cmd_nxt    = head_cmd;
      idx_nxt    = (head_cmd.kind == KIND_PAYLOAD) ? IDX_PAYLOAD : '0;
    end else if (step && at_pay) begin
      active_nxt = 1'b0;
    end else if (step) begin
      // single-packet NALs skip the two FU bytes
      idx_nxt = (cmd_r.kind == KIND_SINGLE && idx_r == IDX_HDR_LAST) ? IDX_PAYLOAD
                : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ovalid_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      active_r <= active_nxt;
      ovalid_r <= ovalid_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    obyte_r <= obyte_nxt;
    oend_r  <= oend_nxt;
    olast_r <= olast_nxt;
  end

  assign out_m.valid      = ovalid_r;
  assign out_m.out_byte   = obyte_r;
  assign out_m.packet_end = oend_r;
  assign out_m.run_last   = olast_r;

endmodule

// File: bench/h264_rtp_fua_packetizer_test.sv
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer_test
// Feeds NAL bytes through the packetizer and checks every framed output
// byte. A directed table covers the boundaries; random NALs under changing
// register settings follow. Most bytes are checked against an in-bench model.
// ----------------------------------------------------------------------------
module h264_rtp_fua_packetizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hfp_pkg::*;

  // run shape
  localparam int RAND_BEATS   = 100;   // random NAL bytes to send
  localparam int SETTLE       = 40;    // quiet cycles before a register write
  localparam int DRAIN_CYCLES = 40;    // watch for stray bytes at the end
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int IDLE_LIMIT   = 5000;  // watchdog: cycles without any beat
  localparam int MAX_PRINTS   = 50;

  // how a directed row's output is checked
  typedef enum logic [1:0] {
    CHK_MODEL,  // by the bench model
    CHK_NONE,   // beat must produce no output
    CHK_BODY,   // one byte echoed, packet still open
    CHK_TAIL    // one byte echoed, closes the packet
  } check_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [31:0] cfg_val;
    logic [7:0]  nal_byte;
    logic [23:0] nal_size;
    logic [31:0] pts;
    check_t      chk;
  } step_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       pkt_end;
    logic       run_last;
  } stream_byte_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  localparam int DIR_ROWS = 31;

  // Directed table. Reset defaults first, then extreme register values with
  // a limit of 4, then a fragment_size of zero (read as a limit of one).
  step_row_t dir_tab [DIR_ROWS] = '{
    // defaults: one-byte NAL at time zero, zero size read as one
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'h00, 24'd1,        32'h0000_0000, CHK_MODEL},
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'hff, 24'd0,        32'hffff_ffff, CHK_MODEL},
    // three-byte single packet; mid-NAL size/time are junk and ignored
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'h65, 24'd3,        32'd1000,      CHK_MODEL},
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'haa, 24'hff_ffff,  32'hffff_ffff, CHK_BODY},
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'h55, 24'd0,        32'h0000_0000, CHK_TAIL},
    // payload type, source id, channel to top values, clock multiplier 1000, limit 4
    '{ROW_CFG,  REG_PAYLOAD_TYPE,     32'd127,       8'h00, 24'd0, 32'd0, CHK_MODEL},
    '{ROW_CFG,  REG_SOURCE_ID,        32'hffff_ffff, 8'h00, 24'd0, 32'd0, CHK_MODEL},
    '{ROW_CFG,  REG_CHANNEL_NUMBER,   32'd255,       8'h00, 24'd0, 32'd0, CHK_MODEL},
    '{ROW_CFG,  REG_FRAGMENT_SIZE,    32'd4,         8'h00, 24'd0, 32'd0, CHK_MODEL},
    '{ROW_CFG,  REG_CLOCK_MULTIPLIER, 32'd1000,      8'h00, 24'd0, 32'd0, CHK_MODEL},
    // size equal to the limit goes fragmented: header byte swallowed,
    // then one fragment carrying both start and end bits
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'hff, 24'd4,        32'h0041_8937, CHK_NONE},
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'h11, 24'h80_0000,  32'h8000_0000, CHK_MODEL},
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'h22, 24'd0,        32'd0,         CHK_BODY},
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'h33, 24'd7,        32'd5,         CHK_TAIL},
    // six bytes: a full fragment of four then a last fragment of one
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'h00, 24'd6,        32'hffff_ffff, CHK_NONE},
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'h01, 24'd0,        32'd0,         CHK_MODEL},
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'h02, 24'd0,        32'd0,         CHK_BODY},
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'h03, 24'd0,        32'd0,         CHK_BODY},
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'h04, 24'd0,        32'd0,         CHK_TAIL},
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'h05, 24'd0,        32'd0,         CHK_MODEL},
    // registers to their bottom values (clock multiplier one), fragment_size zero
    '{ROW_CFG,  REG_PAYLOAD_TYPE,     32'd0,         8'h00, 24'd0, 32'd0, CHK_MODEL},
    '{ROW_CFG,  REG_SOURCE_ID,        32'd0,         8'h00, 24'd0, 32'd0, CHK_MODEL},
    '{ROW_CFG,  REG_CHANNEL_NUMBER,   32'd0,         8'h00, 24'd0, 32'd0, CHK_MODEL},
    '{ROW_CFG,  REG_FRAGMENT_SIZE,    32'd0,         8'h00, 24'd0, 32'd0, CHK_MODEL},
    '{ROW_CFG,  REG_CLOCK_MULTIPLIER, 32'd1,         8'h00, 24'd0, 32'd0, CHK_MODEL},
    // limit one: a one-byte NAL sends nothing at all
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'h7c, 24'd1,        32'd5,         CHK_NONE},
    // two and three bytes: one-byte fragments
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'h9f, 24'd2,        32'd6,         CHK_NONE},
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'hee, 24'd0,        32'd0,         CHK_MODEL},
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'h41, 24'd3,        32'd7,         CHK_NONE},
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'h12, 24'd0,        32'd0,         CHK_MODEL},
    '{ROW_BEAT, REG_PAYLOAD_TYPE, 32'd0, 8'h34, 24'd0,        32'd0,         CHK_MODEL}
  };

  logic clk = 1'b0;
  logic rst_n;

  hfp_in_if  in_if();
  hfp_out_if out_if();
  hfp_cfg_if cfg_if();

  // check mode travels with each input beat, driven alongside the payload
  check_t beat_chk;

  h264_rtp_fua_packetizer uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_m (out_if),
    .cfg_s (cfg_if)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench model of the packetizer: register copy and stream state
  // --------------------------------------------------------------------------
  cfg_t        regs_m;
  logic [15:0] seq_no;
  int          nal_left;    // NAL bytes still to come; 0 = no NAL open
  int          pkt_left;    // payload bytes left in the open packet
  logic        frag_on;
  logic        first_frag;
  logic [7:0]  nal_hdr;
  logic [31:0] ts_word;

  stream_byte_t beat_out[$];   // bytes caused by the beat just taken
  stream_byte_t frame_q[$];    // bytes still owed by the block

  int err_cnt = 0;
  int out_cnt = 0;

  // effective fragment limit: zero reads as one, clipped to the buffer
  function automatic int frag_limit(input int fs);
    int lim;
    lim = fs;
    if (lim == 0) lim = 1;
    if (lim > int'(FRAG_MAX)) lim = int'(FRAG_MAX);
    return lim;
  endfunction

  task automatic emit(input logic [7:0] b, input logic e, input logic l);
    beat_out.push_back({b, e, l});
  endtask

  // '$', channel, length, then the 12-byte RTP header; bumps the sequence
  task automatic emit_header(input logic [15:0] len, input logic marker);
    emit(BYTE_DOLLAR, 1'b0, 1'b0);
    emit(regs_m.channel_number, 1'b0, 1'b0);
    emit(len[15:8], 1'b0, 1'b0);
    emit(len[7:0], 1'b0, 1'b0);
    emit(RTP_V2, 1'b0, 1'b0);
    emit({marker, regs_m.payload_type}, 1'b0, 1'b0);
    emit(seq_no[15:8], 1'b0, 1'b0);
    emit(seq_no[7:0], 1'b0, 1'b0);
    emit(ts_word[31:24], 1'b0, 1'b0);
    emit(ts_word[23:16], 1'b0, 1'b0);
    emit(ts_word[15:8], 1'b0, 1'b0);
    emit(ts_word[7:0], 1'b0, 1'b0);
    emit(regs_m.source_id[31:24], 1'b0, 1'b0);
    emit(regs_m.source_id[23:16], 1'b0, 1'b0);
    emit(regs_m.source_id[15:8], 1'b0, 1'b0);
    emit(regs_m.source_id[7:0], 1'b0, 1'b0);
    seq_no = seq_no + 16'd1;
  endtask

  // works out the bytes one NAL byte causes, into beat_out
  task automatic packetize(input logic [7:0] b, input logic [23:0] sz,
                           input logic [31:0] pts);
    int          size;
    int          lim;
    int          chunk;
    logic        last;
    logic [7:0]  fuh;
    logic [63:0] prod;
    beat_out.delete();
    if (nal_left == 0) begin
      lim = frag_limit(regs_m.fragment_size);
      prod = 64'(pts) * 64'(regs_m.clock_multiplier);
      ts_word = prod[31:0];
      size = sz;
      if (size == 0) size = 1;
      if (size < lim) begin
        frag_on = 1'b0;
        first_frag = 1'b0;
        nal_left = size;
        pkt_left = size;
        emit_header(16'(size) + LEN_SINGLE, 1'b1);
      end else begin
        // NAL header byte is folded into the FU bytes, nothing goes out now
        frag_on = 1'b1;
        first_frag = 1'b1;
        nal_hdr = b;
        nal_left = size - 1;
        pkt_left = 0;
        return;
      end
    end else if (frag_on && pkt_left == 0) begin
      lim = frag_limit(regs_m.fragment_size);
      chunk = (nal_left < lim) ? nal_left : lim;
      last = (chunk == nal_left);
      fuh = (nal_hdr & TYPE_MASK) | (first_frag ? FU_START_BIT : 8'h00)
          | (last ? FU_END_BIT : 8'h00);
      emit_header(16'(chunk) + LEN_FRAG, last);
      emit((nal_hdr & NRI_MASK) | FU_A_TYPE, 1'b0, 1'b0);
      emit(fuh, 1'b0, 1'b0);
      first_frag = 1'b0;
      pkt_left = chunk;
    end
    pkt_left = pkt_left - 1;
    nal_left = nal_left - 1;
    emit(b, pkt_left == 0, 1'b1);
  endtask

  task automatic report(input string what);
    if (err_cnt < MAX_PRINTS) $display("%0t: mismatch: %s", $realtime, what);
    err_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Monitor: all three channels in one process, so a beat taken and a byte
  // checked at the same edge never race. Inputs are predicted first.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    stream_byte_t want;
    if (!rst_n) begin
      regs_m = CFG_RESET;
      seq_no = '0;
      nal_left = 0;
      pkt_left = 0;
      frag_on = 1'b0;
      first_frag = 1'b0;
      nal_hdr = '0;
      ts_word = '0;
      frame_q.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (reg_idx_t'(cfg_if.index))
          REG_PAYLOAD_TYPE:     regs_m.payload_type     = cfg_if.data[6:0];
          REG_SOURCE_ID:        regs_m.source_id        = cfg_if.data;
          REG_CHANNEL_NUMBER:   regs_m.channel_number   = cfg_if.data[7:0];
          REG_FRAGMENT_SIZE:    regs_m.fragment_size    = cfg_if.data[10:0];
          REG_CLOCK_MULTIPLIER: regs_m.clock_multiplier = cfg_if.data[9:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        // model always runs to keep its state; fixed rows replace its bytes
        packetize(in_if.nal_byte, in_if.nal_size, in_if.presentation_time);
        case (beat_chk)
          CHK_MODEL: foreach (beat_out[i]) frame_q.push_back(beat_out[i]);
          CHK_BODY:  frame_q.push_back({in_if.nal_byte, 1'b0, 1'b1});
          CHK_TAIL:  frame_q.push_back({in_if.nal_byte, 1'b1, 1'b1});
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        if (frame_q.size() == 0) begin
          report($sformatf("out beat %0d: byte %h with nothing expected",
                           out_cnt, out_if.out_byte));
        end else begin
          want = frame_q.pop_front();
          if (out_if.out_byte !== want.data)
            report($sformatf("out beat %0d: out_byte %h, expected %h",
                             out_cnt, out_if.out_byte, want.data));
          if (out_if.packet_end !== want.pkt_end)
            report($sformatf("out beat %0d: packet_end %b, expected %b",
                             out_cnt, out_if.packet_end, want.pkt_end));
          if (out_if.run_last !== want.run_last)
            report($sformatf("out beat %0d: run_last %b, expected %b",
                             out_cnt, out_if.run_last, want.run_last));
        end
        out_cnt++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without a beat on any channel ends the run
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: watchdog, no beat for %0d cycles", $realtime, IDLE_LIMIT);
          $display("** h264_rtp_fua_packetizer: FAILED **");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern switches among random modes; one long
  // hold-off on request so the queue fills and the input stalls.
  // --------------------------------------------------------------------------
  bit       hold_req = 1'b0;   // set by the sender
  bit       hold_taken = 1'b0;
  int       hold_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       mode_left = 0;

  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN: out_if.ready <= 1'b1;
        RX_COIN: out_if.ready <= 1'($urandom_range(0, 1));
        default: out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int cur_frag = CFG_RESET.fragment_size;  // sender's copy, sizes the NALs
  int rand_sent = 0;

  // one input beat; called and returns just after a falling edge. Valid
  // stays high across a burst; a new burst starts after a random gap.
  task automatic drive_beat(input logic [7:0] b, input logic [23:0] sz,
                            input logic [31:0] pts, input check_t chk);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid             <= 1'b1;
    in_if.nal_byte          <= b;
    in_if.nal_size          <= sz;
    in_if.presentation_time <= pts;
    beat_chk                <= chk;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    burst_left--;
  endtask

  // input quiet, all owed bytes out, then let a swallowed header byte settle
  task automatic settle_idle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (frame_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    if (idx == REG_FRAGMENT_SIZE) cur_frag = val[10:0];
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // a NAL of random bytes; first beat carries size and time, later beats junk
  task automatic send_nal(input int len);
    logic [23:0] sz;
    logic [31:0] pts;
    int k;
    sz = (len == 1 && $urandom_range(0, 1) == 1) ? 24'd0 : 24'(len);
    case ($urandom_range(0, 5))
      0:       pts = '0;
      1:       pts = '1;
      default: pts = $urandom;
    endcase
    drive_beat(8'($urandom_range(0, 255)), sz, pts, CHK_MODEL);
    for (k = 1; k < len; k++)
      drive_beat(8'($urandom_range(0, 255)), 24'($urandom), $urandom, CHK_MODEL);
    rand_sent += len;
  endtask

  // new register setting for a phase: limit always, the rest by coin
  task automatic random_setting();
    int fs;
    case ($urandom_range(0, 9))
      0:       fs = 1;
      1:       fs = 0;
      2:       fs = 1442;
      3:       fs = 2047;
      default: fs = $urandom_range(2, 24);
    endcase
    cfg_write(REG_FRAGMENT_SIZE, 32'(fs));
    if ($urandom_range(0, 1)) cfg_write(REG_PAYLOAD_TYPE, $urandom_range(0, 127));
    if ($urandom_range(0, 1)) cfg_write(REG_SOURCE_ID, $urandom);
    if ($urandom_range(0, 1)) cfg_write(REG_CHANNEL_NUMBER, $urandom_range(0, 255));
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0:       cfg_write(REG_CLOCK_MULTIPLIER, 32'd1);
        1:       cfg_write(REG_CLOCK_MULTIPLIER, 32'd1000);
        default: cfg_write(REG_CLOCK_MULTIPLIER, $urandom_range(0, 1023));
      endcase
    end
  endtask

  initial begin : stimulus
    int  r;
    int  phase;
    int  lim;
    int  hi;
    bit  prev_cfg;
    // every block input known from time zero
    rst_n                   = 1'b0;
    in_if.valid             = 1'b0;
    in_if.nal_byte          = '0;
    in_if.nal_size          = '0;
    in_if.presentation_time = '0;
    out_if.ready            = 1'b0;
    cfg_if.valid            = 1'b0;
    cfg_if.index            = REG_PAYLOAD_TYPE;
    cfg_if.data             = '0;
    beat_chk                = CHK_MODEL;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed table; register rows only once the block has gone quiet
    prev_cfg = 1'b0;
    for (r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        if (!prev_cfg) settle_idle();
        cfg_write(dir_tab[r].idx, dir_tab[r].cfg_val);
        prev_cfg = 1'b1;
      end else begin
        drive_beat(dir_tab[r].nal_byte, dir_tab[r].nal_size, dir_tab[r].pts,
                   dir_tab[r].chk);
        prev_cfg = 1'b0;
      end
    end

    // random phases: new setting, then a few NALs sized around the limit so
    // both single packets and multi-fragment NALs show up
    phase = 0;
    while (rand_sent < RAND_BEATS) begin
      settle_idle();
      random_setting();
      // first phase: receiver holds off while NALs keep coming
      if (phase == 0) hold_req = 1'b1;
      repeat ($urandom_range(1, 3)) begin
        lim = frag_limit(cur_frag);
        hi = 3 * lim + 2;
        if (hi > 40) hi = 40;
        send_nal($urandom_range(1, hi));
      end
      phase++;
    end

    // clipped limit: fragment_size above the buffer acts as 1442, so a NAL
    // of exactly that length fragments. Its header byte sends nothing and
    // the next byte opens a last fragment of 1441; the NAL stays open.
    settle_idle();
    cfg_write(REG_FRAGMENT_SIZE, 32'd2047);
    drive_beat(8'($urandom_range(0, 255)), 24'(FRAG_MAX), $urandom, CHK_MODEL);
    drive_beat(8'($urandom_range(0, 255)), 24'($urandom), $urandom, CHK_MODEL);

    in_if.valid <= 1'b0;
    while (frame_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0) begin
      $display("** h264_rtp_fua_packetizer: PASSED **");
    end else begin
      $display("** h264_rtp_fua_packetizer: FAILED **");
    end
    $finish;
  end

endmodule
